// File: rtl/dmeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dmeq_pkg;
  localparam int unsigned DBias = 1023;
  localparam int unsigned QBias = 16383;
  localparam int unsigned FracBits = 52;
  localparam int unsigned SignBit = 63;

  typedef struct packed {
    logic [63:0] op_a;
    logic [63:0] op_b;
  } in_t;

  typedef struct packed {
    logic [63:0] product_high;
    logic [63:0] product_low;
  } out_t;

  typedef struct packed {
    logic        zero;
    logic        sign;
    logic [11:0] exp_sum;
  } side_t;
endpackage
`default_nettype wire

// File: rtl/double_multiply_exact_quad_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle.
// busy is always low; a new item may enter every cycle.
// Stages: operand split, partial products, product sum, normalize and pack.
// Synchronous reset clears the valid pipeline; the receiver cannot stall.
module double_multiply_exact_quad_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire dmeq_pkg::in_t   in_item,
  output logic                 done,
  output dmeq_pkg::out_t       out_item
);
  logic [2:0] valid;
  logic [52:0] ma, mb;
  dmeq_pkg::side_t s1, s2, s3;
  logic [105:0] prod;
  logic [14:0] e;
  logic [111:0] frac;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    ma <= {1'b1, in_item.op_a[51:0]};
    mb <= {1'b1, in_item.op_b[51:0]};
    s1.zero <= (in_item.op_a[62:0] == '0) || (in_item.op_b[62:0] == '0);
    s1.sign <= in_item.op_a[dmeq_pkg::SignBit] ^ in_item.op_b[dmeq_pkg::SignBit];
    s1.exp_sum <= {1'b0, in_item.op_a[62:52]} + {1'b0, in_item.op_b[62:52]};
    s2 <= s1;
    s3 <= s2;
  end

  dmeq_mul u_mul (.clk(clk), .ma(ma), .mb(mb), .prod(prod));

  always_comb begin
    e = 15'({3'd0, s3.exp_sum} + 15'(dmeq_pkg::QBias - 2 * dmeq_pkg::DBias)
          + {14'd0, prod[105]});
    if (prod[105]) begin
      frac = {prod[104:0], 7'd0};
    end else begin
      frac = {prod[103:0], 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (s3.zero) begin
      out_item <= '0;
    end else begin
      out_item.product_high <= {s3.sign, e, frac[111:64]};
      out_item.product_low  <= frac[63:0];
    end
  end
endmodule
`default_nettype wire

// File: rtl/dmeq_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module dmeq_mul (
  input  wire logic         clk,
  input  wire logic [52:0]  ma,
  input  wire logic [52:0]  mb,
  output logic      [105:0] prod
);
  logic [26:0] al, bl;
  logic [25:0] ah, bh;
  logic [53:0] p_ll, p_hh;
  logic [52:0] p_lh, p_hl;

  assign al = ma[26:0];
  assign ah = ma[52:27];
  assign bl = mb[26:0];
  assign bh = mb[52:27];

  always_ff @(posedge clk) begin
    p_ll <= al * bl;
    p_lh <= {26'd0, al} * {27'd0, bh};
    p_hl <= {27'd0, ah} * {26'd0, bl};
    p_hh <= {28'd0, ah} * {28'd0, bh};
  end

  always_ff @(posedge clk) begin
    prod <= {52'd0, p_ll} + ({53'd0, p_lh} << 27) + ({53'd0, p_hl} << 27)
          + ({52'd0, p_hh} << 54);
  end
endmodule
`default_nettype wire

// File: tb/tb_double_multiply_exact_quad_top.sv
`timescale 1ns / 1ps
module tb_double_multiply_exact_quad_top;

  class product_board;
    dmeq_pkg::out_t pending[$];
    int errors;
    int checked;

    function automatic dmeq_pkg::out_t exact_product(dmeq_pkg::in_t x);
      dmeq_pkg::out_t r;
      logic [52:0] ma, mb;
      logic [105:0] p;
      logic [111:0] frac;
      logic [14:0] ex;
      logic s;
      r = '0;
      if (x.op_a[62:0] == 63'd0 || x.op_b[62:0] == 63'd0) return r;
      s = x.op_a[dmeq_pkg::SignBit] ^ x.op_b[dmeq_pkg::SignBit];
      ma = {1'b1, x.op_a[51:0]};
      mb = {1'b1, x.op_b[51:0]};
      p = ma * mb;
      ex = 15'(x.op_a[62:52]) + 15'(x.op_b[62:52]) - 15'(2 * dmeq_pkg::DBias)
         + 15'(dmeq_pkg::QBias);
      if (p[105]) begin
        frac = {p[104:0], 7'd0};
        ex = ex + 15'd1;
      end else begin
        frac = {p[103:0], 8'd0};
      end
      r.product_high = {s, ex, frac[111:64]};
      r.product_low = frac[63:0];
      return r;
    endfunction

    function void note_item(dmeq_pkg::in_t x);
      pending.push_back(exact_product(x));
    endfunction

    function void check_result(dmeq_pkg::out_t got);
      dmeq_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.product_high !== want.product_high) begin
        $error("product_high expected %h actual %h", want.product_high, got.product_high);
        errors++;
      end
      if (got.product_low !== want.product_low) begin
        $error("product_low expected %h actual %h", want.product_low, got.product_low);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  dmeq_pkg::in_t in_item = '0;
  logic busy, done;
  dmeq_pkg::out_t out_item;
  int idle_pct = 0;
  int quiet = 0;
  int sent = 0;
  product_board board = new();

  double_multiply_exact_quad_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .done(done), .out_item(out_item)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) board.check_result(out_item);
    if (!rst && ((start && !busy) || done)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 2000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v[62:52] = 11'd0;
      1: v[62:52] = 11'h7ff;
      2: v[51:0] = 52'd0;
      3: v[51:0] = '1;
      4: v[62:0] = 63'd0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(logic [63:0] a, logic [63:0] b);
    dmeq_pkg::in_t x;
    x.op_a = a;
    x.op_b = b;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(x);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  logic [63:0] edge_vals[10] = '{
    64'h0, 64'h8000_0000_0000_0000, 64'h3ff0_0000_0000_0000,
    64'hbff0_0000_0000_0000, 64'h3fff_ffff_ffff_ffff, 64'h7fef_ffff_ffff_ffff,
    64'h0000_0000_0000_0001, 64'h7ff0_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
    64'h0010_0000_0000_0000};

  initial begin
    int phases[4] = '{0, 79, 0, 31};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 10; i++) send_item(edge_vals[i], edge_vals[(i * 3 + 2) % 10]);
    send_item(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000);
    send_item(64'h3fff_ffff_ffff_ffff, 64'h3fff_ffff_ffff_ffff);
    send_item(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0001);
    send_item(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    drain();
    foreach (phases[p]) begin
      idle_pct = phases[p];
      for (int i = 0; i < 225; i++) send_item(rand_double(), rand_double());
      drain();
    end
    $display("Covered %0d operand pairs, %0d products checked, idle rates 0/79/31 pct.",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: double_multiply_exact_quad_top.f
rtl/dmeq_pkg.sv
rtl/dmeq_mul.sv
rtl/double_multiply_exact_quad_top.sv
tb/tb_double_multiply_exact_quad_top.sv
